/* rtl/core/merge_sorter_macros.svh */
// assertion shorthands, sampled on clock and held off while reset is high
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// consequence checked in the same cycle
`define MS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the next cycle
`define MS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ms_pkg.sv */
package ms_pkg;

   localparam int unsigned MAX_ITEMS_DEF = 64;
   localparam int unsigned VALUE_W       = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic                      overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PRIME,
      ST_MERGE,
      ST_OUT_RD,
      ST_SHOW
   } state_type;

endpackage

/* rtl/core/merge_sorter.sv */
// Collects signed 32-bit words, one per cycle, until a word marked is_last,
// then sorts the set ascending with a stable bottom-up merge sort (equal values
// keep arrival order) and sends it out with the final word marked. Up to
// MAX_ITEMS words are kept; later words of the set are dropped and every output
// word of that run carries the overflow flag. One compare-and-write unit merges
// one word per cycle, ping-ponging between two buffers with two read ports each.
// For n words the sort takes ceil(log2 n) passes, each opened by a priming state
// that loads the read registers; each output word goes through a read state and
// then a show state, where it is held until rsp_ready.
// req_ready is high only while loading.
module merge_sorter #(
   parameter int unsigned MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ms_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ms_pkg::rsp_type rsp_data
);

   localparam int unsigned ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int unsigned IDX_W  = CNT_W + 1;

   ms_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              par_ff, par_in;
   logic [IDX_W-1:0]  width_ff, width_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;

   logic                              a_we, b_we;
   logic [ADDR_W-1:0]                 wr_addr;
   logic signed [ms_pkg::VALUE_W-1:0] wr_data;
   logic signed [ms_pkg::VALUE_W-1:0] a_rd_i, a_rd_j, b_rd_i, b_rd_j;
   logic signed [ms_pkg::VALUE_W-1:0] src_i, src_j;

   logic [IDX_W-1:0] n_ext, mid_raw, hi_raw, mid, hi;
   logic [IDX_W-1:0] lo_next, width_dbl, next_mid_raw;
   logic [CNT_W-1:0] count_next;
   logic             take_i;

   ms_ram #(.DEPTH(MAX_ITEMS)) u_elem_ram (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_i (i_in[ADDR_W-1:0]),
      .rd_addr_j (j_in[ADDR_W-1:0]),
      .rd_data_i (a_rd_i),
      .rd_data_j (a_rd_j)
   );

   ms_ram #(.DEPTH(MAX_ITEMS)) u_scratch_ram (
      .clock     (clock),
      .wr_en     (b_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_i (i_in[ADDR_W-1:0]),
      .rd_addr_j (j_in[ADDR_W-1:0]),
      .rd_data_i (b_rd_i),
      .rd_data_j (b_rd_j)
   );

   // par_ff selects the buffer that holds the current source run
   assign src_i = par_ff ? b_rd_i : a_rd_i;
   assign src_j = par_ff ? b_rd_j : a_rd_j;

   assign n_ext        = IDX_W'(count_ff);
   assign mid_raw      = lo_ff + width_ff;
   assign hi_raw       = lo_ff + (width_ff << 1);
   assign mid          = (mid_raw > n_ext) ? n_ext : mid_raw;
   assign hi           = (hi_raw > n_ext) ? n_ext : hi_raw;
   assign lo_next      = hi_raw;
   assign width_dbl    = width_ff << 1;
   assign next_mid_raw = lo_next + width_ff;

   // ties go to the left run so the sort stays stable
   assign take_i = (i_ff < mid) && ((j_ff >= hi) || (src_i <= src_j));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ms_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      par_ff   <= par_in;
      width_ff <= width_in;
      lo_ff    <= lo_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      par_in     = par_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      a_we       = 1'b0;
      b_we       = 1'b0;
      wr_addr    = k_ff[ADDR_W-1:0];
      wr_data    = take_i ? src_i : src_j;
      count_next = count_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         ms_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  a_we       = 1'b1;
                  wr_addr    = count_ff[ADDR_W-1:0];
                  wr_data    = req_data.value;
                  count_next = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = count_next;
               if (req_data.is_last) begin
                  par_in   = 1'b0;
                  width_in = IDX_W'(1);
                  lo_in    = '0;
                  k_in     = '0;
                  i_in     = '0;
                  j_in     = IDX_W'(1);
                  if (count_next >= CNT_W'(2)) begin
                     state_in = ms_pkg::ST_PRIME;
                  end else begin
                     state_in = ms_pkg::ST_OUT_RD;
                  end
               end
            end
         end

         ms_pkg::ST_PRIME: begin
            state_in = ms_pkg::ST_MERGE;
         end

         ms_pkg::ST_MERGE: begin
            a_we = par_ff;
            b_we = ~par_ff;
            k_in = k_ff + IDX_W'(1);
            if (take_i) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
            if (k_ff + IDX_W'(1) == hi) begin
               if (lo_next >= n_ext) begin
                  // pass done: swap buffers and double the run width
                  par_in   = ~par_ff;
                  width_in = width_dbl;
                  lo_in    = '0;
                  k_in     = '0;
                  i_in     = '0;
                  j_in     = width_dbl;
                  if (width_dbl >= n_ext) begin
                     state_in = ms_pkg::ST_OUT_RD;
                  end else begin
                     state_in = ms_pkg::ST_PRIME;
                  end
               end else begin
                  lo_in = lo_next;
                  i_in  = lo_next;
                  j_in  = (next_mid_raw > n_ext) ? n_ext : next_mid_raw;
               end
            end
         end

         ms_pkg::ST_OUT_RD: begin
            state_in = ms_pkg::ST_SHOW;
         end

         ms_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (i_ff + IDX_W'(1) == n_ext) begin
                  state_in = ms_pkg::ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ms_pkg::ST_OUT_RD;
               end
            end
         end

         default: begin
            state_in = ms_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_data.sorted_value = src_i;
   assign rsp_data.last_out     = (i_ff + IDX_W'(1) == n_ext);
   assign rsp_data.overflow     = ovf_ff;

endmodule

/* rtl/core/ms_ram.sv */
module ms_ram #(
   parameter int unsigned DEPTH = ms_pkg::MAX_ITEMS_DEF,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic signed [ms_pkg::VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                 rd_addr_i,
   input  logic [ADDR_W-1:0]                 rd_addr_j,
   output logic signed [ms_pkg::VALUE_W-1:0] rd_data_i,
   output logic signed [ms_pkg::VALUE_W-1:0] rd_data_j
);

   logic signed [ms_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [ms_pkg::VALUE_W-1:0] rd_i_ff;
   logic signed [ms_pkg::VALUE_W-1:0] rd_j_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_i_ff <= mem[rd_addr_i];
      rd_j_ff <= mem[rd_addr_j];
   end

   assign rd_data_i = rd_i_ff;
   assign rd_data_j = rd_j_ff;

endmodule

/* rtl/core/ms_checker.sv */
`include "merge_sorter_macros.svh"

module ms_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input ms_pkg::req_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input ms_pkg::rsp_type rsp_data
);

   // no new word is taken while a sorted word is on offer
   `MS_ASSERT_SAME(a_no_load_while_out, rsp_valid, !req_ready, "req_ready high during output")

   // a word that does not end the set never starts the output run
   `MS_ASSERT_NEXT(a_no_out_after_mid, req_valid && req_ready && !req_data.is_last, !rsp_valid, "output started before last word")

   // once the final word leaves, loading resumes
   `MS_ASSERT_NEXT(a_load_after_run, rsp_valid && rsp_ready && rsp_data.last_out, req_ready && !rsp_valid, "not back to loading after run")

   // a stalled output word holds
   `MS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "output word changed under stall")

endmodule

bind merge_sorter ms_checker u_ms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
